@@ rtl/core/hierarchical_tile_map_fetch_unit_assert.svh @@
// assertion macros for the tile map fetch unit
// used by the checker module; no other dependencies
`ifndef HIERARCHICAL_TILE_MAP_FETCH_UNIT_ASSERT_SVH
`define HIERARCHICAL_TILE_MAP_FETCH_UNIT_ASSERT_SVH
// same-cycle implication
`define HTMF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tile map fetch assertion failed");
// next-cycle implication
`define HTMF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tile map fetch assertion failed");
`endif

@@ rtl/core/htmf_pkg.sv @@
// shared types and constants of the tile map fetch unit
// no dependencies
package htmf_pkg;
	localparam int MAP_BYTES = 65536;
	localparam int MAP_AW = $clog2(MAP_BYTES);
	localparam logic [15:0] ROOM_TABLE = 16'h5000;
	localparam logic [16:0] ENTRY_LIMIT = 17'h0fffe;
	localparam logic [15:0] PANEL_LIMIT = 16'hfffc;
	localparam logic [14:0] WORLD_LOW = 15'h4c00;
	localparam logic [14:0] WORLD_HIGH = 15'h4f00;
	localparam logic [14:0] WORLD_RESET = 15'h4c00;
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;
	localparam logic REG_MAP_READY = 1'b0;
	localparam logic REG_WORLD_BASE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [15:0] load_address;
		logic [7:0]  load_byte;
		logic [12:0] pos_x;
		logic [11:0] pos_y;
	} in_t;

	typedef struct packed {
		logic [7:0] tile_index;
		logic       found;
	} out_t;

	// position fields carried down the pipeline
	typedef struct packed {
		logic [3:0] y_sub;
		logic [3:0] x_sub;
		logic       x_half;
		logic       y_half;
		logic       bad;
	} lk_t;
endpackage

@@ rtl/core/htmf_ram.sv @@
// generic ram: one write port, two registered read ports
// no dependencies
module htmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re0,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	output logic [WIDTH-1:0]         rdata0,
	input  logic                     re1,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata1
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re0) begin
			rdata0 <= mem_q[raddr0];
		end
		if (re1) begin
			rdata1 <= mem_q[raddr1];
		end
	end
endmodule

@@ rtl/core/hierarchical_tile_map_fetch_unit.sv @@
// top level of the tile map fetch unit
// depends on htmf_pkg and htmf_ram
//
// a lookup walks a four-level pointer chain (room grid, room table row, panel
// pointer, tile byte) through a five-stage pipeline and takes one lookup per
// cycle in steady state while nothing stalls. the levels read three copies of
// the 64 KiB map (copy a serves room and tile bytes on its two ports), so the
// chain never waits on a shared port. a map byte write goes into all copies at
// once and is held off until lookups still reading have left the read stages;
// writes produce no result transaction. the whole pipeline holds while a
// finished result waits under out_stall.
module hierarchical_tile_map_fetch_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  htmf_pkg::in_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output htmf_pkg::out_t out_data,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import htmf_pkg::*;

	// configuration registers
	logic        map_ready_q;
	logic [14:0] world_base_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_ready_q  <= 1'b0;
			world_base_q <= WORLD_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MAP_READY:  map_ready_q  <= pwdata[0];
				REG_WORLD_BASE: world_base_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAP_READY:  prdata = {31'b0, map_ready_q};
			REG_WORLD_BASE: prdata = {17'b0, world_base_q};
			default:        prdata = '0;
		endcase
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	lk_t  lk_s1, lk_s2, lk_s3, lk_s4;
	logic adv;        // whole pipeline moves
	logic busy;       // a lookup is still reading the map
	logic acc;
	logic acc_lookup;
	logic map_we;

	assign adv        = !(out_valid && out_stall);
	assign busy       = v_s1 | v_s2 | v_s3 | v_s4;
	// a write must not overtake reads of lookups ahead of it
	assign in_stall   = !adv || (in_data.action == ACT_WRITE && busy);
	assign acc        = in_valid && !in_stall;
	assign acc_lookup = acc && in_data.action == ACT_LOOKUP;
	assign map_we     = acc && in_data.action == ACT_WRITE;

	// stage 0: room grid address and configuration checks
	logic [15:0] room_addr;
	logic        cfg_bad;
	lk_t         lk_in;

	assign room_addr = {1'b0, world_base_q} + {7'b0, in_data.pos_y[11:8], 5'b0}
		+ {11'b0, in_data.pos_x[12:8]};
	assign cfg_bad = !map_ready_q || world_base_q < WORLD_LOW
		|| world_base_q > WORLD_HIGH || world_base_q[7:0] != 8'h00;
	assign lk_in = '{y_sub: in_data.pos_y[7:4], x_sub: in_data.pos_x[7:4],
		x_half: in_data.pos_x[3], y_half: in_data.pos_y[3], bad: cfg_bad};

	// stage 1: room byte -> room table row address
	logic [7:0]  room_byte;
	logic [15:0] row_addr;
	logic [15:0] row_addr_hi;

	assign row_addr    = ROOM_TABLE + {3'b0, room_byte, 5'b0} + {11'b0, lk_s1.y_sub, 1'b0};
	assign row_addr_hi = row_addr + 16'd1;

	// stage 2: row pointer -> entry address
	logic [7:0]  row_lo, row_hi;
	logic [16:0] entry;
	logic [15:0] entry_hi;
	logic        bad_s2;

	assign entry    = {1'b0, row_hi, row_lo} + {12'b0, lk_s2.x_sub, 1'b0};
	assign entry_hi = entry[15:0] + 16'd1;
	assign bad_s2   = lk_s2.bad || entry > ENTRY_LIMIT;

	// stage 3: panel pointer -> tile address
	logic [7:0]  pan_lo, pan_hi;
	logic [15:0] panel;
	logic [15:0] tile_addr;

	assign panel     = {pan_hi, pan_lo};
	assign tile_addr = panel + {14'b0, lk_s3.x_half, lk_s3.y_half};

	// stage 4: tile byte
	logic [7:0] tile_byte;
	logic       bad_s3;

	assign bad_s3 = lk_s3.bad || panel > PANEL_LIMIT;

	// copy a: room byte and tile byte
	htmf_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_ram_a (
		.clk    (clk),
		.we     (map_we),
		.waddr  (in_data.load_address),
		.wdata  (in_data.load_byte),
		.re0    (adv),
		.raddr0 (room_addr),
		.rdata0 (room_byte),
		.re1    (adv),
		.raddr1 (tile_addr),
		.rdata1 (tile_byte)
	);

	// copy b: row pointer bytes
	htmf_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_ram_b (
		.clk    (clk),
		.we     (map_we),
		.waddr  (in_data.load_address),
		.wdata  (in_data.load_byte),
		.re0    (adv),
		.raddr0 (row_addr),
		.rdata0 (row_lo),
		.re1    (adv),
		.raddr1 (row_addr_hi),
		.rdata1 (row_hi)
	);

	// copy c: panel pointer bytes
	htmf_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_ram_c (
		.clk    (clk),
		.we     (map_we),
		.waddr  (in_data.load_address),
		.wdata  (in_data.load_byte),
		.re0    (adv),
		.raddr0 (entry[15:0]),
		.rdata0 (pan_lo),
		.re1    (adv),
		.raddr1 (entry_hi),
		.rdata1 (pan_hi)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= acc_lookup;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	// payload registers, held with the ram outputs under stall
	always_ff @(posedge clk) begin
		if (adv) begin
			lk_s1 <= lk_in;
			lk_s2 <= lk_s1;
			lk_s3 <= '{y_sub: lk_s2.y_sub, x_sub: lk_s2.x_sub,
				x_half: lk_s2.x_half, y_half: lk_s2.y_half, bad: bad_s2};
			lk_s4 <= '{y_sub: lk_s3.y_sub, x_sub: lk_s3.x_sub,
				x_half: lk_s3.x_half, y_half: lk_s3.y_half, bad: bad_s3};
			out_data <= '{tile_index: lk_s4.bad ? 8'h00 : tile_byte,
				found: !lk_s4.bad};
		end
	end
endmodule

@@ rtl/core/htmf_checker.sv @@
// port-level checker for the tile map fetch unit, bound to the top level
// depends on htmf_pkg and the assertion macro header
`include "hierarchical_tile_map_fetch_unit_assert.svh"

module htmf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input htmf_pkg::out_t out_data
);
	import htmf_pkg::*;

	// a stalled result holds
	`HTMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
	// a failed lookup reports tile zero
	`HTMF_ASSERT_NOW(a_miss_zero, out_valid && !out_data.found, out_data.tile_index == 8'h00)
	// a waiting result freezes the pipeline, so no new transaction enters
	`HTMF_ASSERT_NOW(a_freeze, out_valid && out_stall, in_stall)
endmodule

bind hierarchical_tile_map_fetch_unit htmf_checker u_htmf_checker (.*);

@@ tb/hierarchical_tile_map_fetch_unit_checker.sv @@
// scoreboard for the tile map fetch unit: mirrors the map and registers,
// predicts each lookup and compares results; depends on htmf_pkg
module hierarchical_tile_map_fetch_unit_checker
	import htmf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_t        out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]  map_copy [MAP_BYTES];
	logic        ready_q;
	logic [14:0] base_q;
	out_t        tile_queue[$];

	initial begin
		fail_count = 0;
		results_seen = 0;
		foreach (map_copy[i]) map_copy[i] = 8'h00;
	end

	assign pending = tile_queue.size();

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic out_t predict_tile(in_t it);
		logic [15:0] room_a, row_a, row, panel;
		logic [7:0]  room;
		logic [16:0] entry;
		out_t        r;
		r = '0;
		if (!ready_q || base_q < WORLD_LOW || base_q > WORLD_HIGH || base_q[7:0] != 8'h00)
			return r;
		room_a = 16'(base_q) + 16'(it.pos_y[11:8]) * 16'd32 + 16'(it.pos_x[12:8]);
		room = map_copy[room_a];
		row_a = ROOM_TABLE + 16'(room) * 16'd32 + 16'(it.pos_y[7:4]) * 16'd2;
		row = {map_copy[16'(row_a + 16'd1)], map_copy[row_a]};
		entry = 17'(row) + 17'(it.pos_x[7:4]) * 17'd2;
		if (entry > ENTRY_LIMIT)
			return r;
		panel = {map_copy[16'(entry[15:0] + 16'd1)], map_copy[entry[15:0]]};
		if (panel > PANEL_LIMIT)
			return r;
		r.tile_index = map_copy[16'(panel + 16'(it.pos_x[3]) * 16'd2 + 16'(it.pos_y[3]))];
		r.found = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			base_q <= WORLD_RESET;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_MAP_READY, 2'b00})
					ready_q <= pwdata[0];
				else if (paddr == {REG_WORLD_BASE, 2'b00})
					base_q <= pwdata[14:0];
			end
			if (in_valid && !in_stall) begin
				if (in_data.action == ACT_WRITE)
					map_copy[in_data.load_address] = in_data.load_byte;
				else
					tile_queue.push_back(predict_tile(in_data));
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (tile_queue.size() == 0) begin
					report_mismatch("unexpected result", int'(out_data), 0);
				end else begin
					out_t want;
					want = tile_queue.pop_front();
					if (out_data.found !== want.found)
						report_mismatch("found", int'(out_data.found), int'(want.found));
					if (out_data.tile_index !== want.tile_index)
						report_mismatch("tile_index", int'(out_data.tile_index),
							int'(want.tile_index));
				end
			end
		end
	end
endmodule

@@ tb/hierarchical_tile_map_fetch_unit_test.sv @@
// top of the tile map fetch unit testbench: clock, reset, stimulus and verdict
// depends on htmf_pkg, the unit and its checker
module hierarchical_tile_map_fetch_unit_test;
	import htmf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 12;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count, pending, results_seen;

	// stimulus side copy of the map, used only to keep lookups on written bytes
	logic [7:0] shadow [MAP_BYTES];
	bit         written [MAP_BYTES];
	logic       cfg_ready = 1'b0;
	logic [14:0] cfg_base = WORLD_RESET;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_tickets = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int items_sent = 0;
	int lookups_sent = 0;
	int quiet_cycles = 0;

	hierarchical_tile_map_fetch_unit u_dut (.*);

	hierarchical_tile_map_fetch_unit_checker u_checker (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
		.out_data, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .pending, .results_seen
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_tickets != hold_seen) begin
			hold_seen++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one input transaction, with random idle cycles ahead of it
	task automatic send(in_t d);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (d.action == ACT_WRITE) begin
			shadow[d.load_address] = d.load_byte;
			written[d.load_address] = 1'b1;
		end else begin
			lookups_sent++;
		end
	endtask

	task automatic write_byte(logic [15:0] a, logic [7:0] b);
		in_t d;
		d = in_t'({$urandom, $urandom});
		d.action = ACT_WRITE;
		d.load_address = a;
		d.load_byte = b;
		send(d);
	endtask

	// pointer bytes lean toward the top of the range so the limit checks get hit
	task automatic define_byte(logic [15:0] a);
		if (!written[a])
			write_byte(a, ($urandom_range(9) == 0) ? 8'hff : 8'($urandom));
	endtask

	// a well-formed sequence: define every byte the chain will read, then look up
	task automatic lookup_at(logic [12:0] x, logic [11:0] y);
		logic [15:0] room_a, row_a, row, panel;
		logic [16:0] entry;
		in_t d;
		if (cfg_ready && cfg_base >= WORLD_LOW && cfg_base <= WORLD_HIGH &&
			cfg_base[7:0] == 8'h00) begin
			room_a = 16'(cfg_base) + 16'(y[11:8]) * 16'd32 + 16'(x[12:8]);
			define_byte(room_a);
			row_a = ROOM_TABLE + 16'(shadow[room_a]) * 16'd32 + 16'(y[7:4]) * 16'd2;
			define_byte(row_a);
			define_byte(16'(row_a + 16'd1));
			row = {shadow[16'(row_a + 16'd1)], shadow[row_a]};
			entry = 17'(row) + 17'(x[7:4]) * 17'd2;
			if (entry <= ENTRY_LIMIT) begin
				define_byte(entry[15:0]);
				define_byte(16'(entry[15:0] + 16'd1));
				panel = {shadow[16'(entry[15:0] + 16'd1)], shadow[entry[15:0]]};
				if (panel <= PANEL_LIMIT)
					define_byte(16'(panel + 16'(x[3]) * 16'd2 + 16'(y[3])));
			end
		end
		d = in_t'({$urandom, $urandom});
		d.action = ACT_LOOKUP;
		d.pos_x = x;
		d.pos_y = y;
		send(d);
	endtask

	// register write in a setup and an access cycle, then an idle cycle
	task automatic reg_write(logic index, logic [31:0] value);
		in_valid <= 1'b0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == REG_MAP_READY)
			cfg_ready = value[0];
		else
			cfg_base = value[14:0];
		@(posedge clk);
	endtask

	// wait until every lookup has answered and trailing writes have settled
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic ready, logic [14:0] base);
		drain();
		reg_write(REG_MAP_READY, {31'($urandom) << 1, ready});
		reg_write(REG_WORLD_BASE, {17'($urandom), base});
	endtask

	// mostly chains with random content, plus stray writes
	task automatic random_phase(int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 75)
				lookup_at(13'($urandom), 12'($urandom));
			else if (pick < 95)
				write_byte(16'($urandom), 8'($urandom));
			else
				lookup_at(13'($urandom_range(8191)), 12'($urandom_range(4095)));
		end
	endtask

	initial begin
		foreach (written[i]) written[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: map not ready after reset, then field extremes
		lookup_at(13'd0, 12'd0);
		lookup_at(13'h1fff, 12'hfff);
		write_byte(16'hffff, 8'hff);
		write_byte(16'h0000, 8'h00);
		configure(1'b1, WORLD_LOW);
		// room 0, row pointer 0xfffe: entry at the limit, panel pointer 0xfffc
		write_byte(16'h4c00, 8'h00);
		write_byte(16'h5000, 8'hfe);
		write_byte(16'h5001, 8'hff);
		write_byte(16'hfffe, 8'hfc);
		write_byte(16'hffff, 8'hff);
		write_byte(16'hfffc, 8'ha5);
		write_byte(16'hfffd, 8'h5a);
		lookup_at(13'd0, 12'd0);
		lookup_at(13'd8, 12'd8);
		// entry just past the limit
		lookup_at(13'd16, 12'd0);
		// panel pointer just past the limit
		write_byte(16'h5002, 8'h00);
		write_byte(16'h5003, 8'h00);
		write_byte(16'h0000, 8'hfd);
		write_byte(16'h0001, 8'hff);
		lookup_at(13'd0, 12'd16);
		lookup_at(13'h1fff, 12'hfff);
		configure(1'b1, WORLD_HIGH);
		lookup_at(13'h1fff, 12'hfff);
		configure(1'b1, 15'h4c80);
		lookup_at(13'd0, 12'd0);
		configure(1'b1, 15'h5000);
		lookup_at(13'd0, 12'd0);

		// random: no idling
		configure(1'b1, WORLD_LOW);
		idle_pct = 0;
		stall_pct = 0;
		random_phase(50);

		// sender mostly idle; pause for all results midway
		configure(1'b1, 15'h4d00);
		idle_pct = 76;
		random_phase(25);
		drain();
		random_phase(25);

		// receiver mostly stalling, with one long hold-off that backs up the input
		configure(1'b1, 15'h4e00);
		idle_pct = 0;
		stall_pct = 76;
		hold_tickets++;
		random_phase(50);

		// both sides idling
		configure(1'b1, WORLD_HIGH);
		idle_pct = 27;
		stall_pct = 27;
		random_phase(35);

		// rejected settings with traffic still flowing
		configure(1'b0, WORLD_HIGH);
		random_phase(10);
		configure(1'b1, 15'h7fff);
		random_phase(10);
		configure(1'b1, 15'h4bff);
		random_phase(10);
		configure(1'b1, 15'h4e01);
		random_phase(10);

		// back to no idling to finish
		configure(1'b1, WORLD_LOW);
		idle_pct = 0;
		stall_pct = 0;
		random_phase(25);

		drain();
		$display("run covered %0d input transactions, %0d of them lookups, %0d results",
			items_sent, lookups_sent, results_seen);
		$display("register settings included not ready, every aligned base and bad bases");
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
